@@ src/sce_pkg.sv @@
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types and constants for the spinal code encoder: hash constants,
// register indexes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package sce_pkg;

  // Hash constants
  localparam logic [31:0] MixC1   = 32'hcc9e2d51;
  localparam logic [31:0] MixC2   = 32'h1b873593;
  localparam logic [31:0] MixC3   = 32'h85ebca6b;
  localparam logic [31:0] MixC4   = 32'hc2b2ae35;
  localparam logic [31:0] PassInc = 32'h9e3779b1;  // 2654435761
  localparam logic [31:0] PassMul = 32'h045d9f3b;

  localparam logic [3:0] MaxPasses  = 4'd8;
  localparam logic [3:0] MaxSymBits = 4'd8;
  localparam logic [3:0] SymBitsRst = 4'd4;
  localparam logic [3:0] PassesRst  = 4'd2;

  // Configuration register indexes
  localparam logic [0:0] RegSymbolBits = 1'b0;
  localparam logic [0:0] RegPasses     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MIX0,
    ST_MIX1,
    ST_MIX2,
    ST_MIX3,
    ST_HASH0,
    ST_HASH1,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_MIX0,
    MUL_MIX1,
    MUL_MIX2,
    MUL_MIX3,
    MUL_HASH0,
    MUL_HASH1
  } mul_op_e;

  typedef struct packed {
    logic    load_byte;
    logic    shift_bit;
    mul_op_e mul_op;
    logic    load_out;
    logic    clear_msg;
  } cmd_t;

  typedef struct packed {
    logic take;       // current shift completes a symbol
    logic left_one;   // one message bit left in the byte
    logic left_zero;  // byte fully consumed
    logic last_pass;
    logic out_busy;
    logic last;
  } status_t;

endpackage

@@ src/sce_ctrl.sv @@
// ----------------------------------------------------------------------------
// sce_ctrl
// Sequencer: shifts message bits, runs the spine mix and one hash per pass,
// and hands each coded bit to the output register.
// ----------------------------------------------------------------------------
module sce_ctrl import sce_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output state_e  state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mul_op = MUL_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_byte = 1'b1;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift_bit = 1'b1;
        if (status_i.take) begin
          state_d = ST_MIX0;
        end else if (status_i.left_one) begin
          state_d = ST_IDLE;
        end
      end
      ST_MIX0: begin
        cmd_o.mul_op = MUL_MIX0;
        state_d = ST_MIX1;
      end
      ST_MIX1: begin
        cmd_o.mul_op = MUL_MIX1;
        state_d = ST_MIX2;
      end
      ST_MIX2: begin
        cmd_o.mul_op = MUL_MIX2;
        state_d = ST_MIX3;
      end
      ST_MIX3: begin
        cmd_o.mul_op = MUL_MIX3;
        state_d = ST_HASH0;
      end
      ST_HASH0: begin
        cmd_o.mul_op = MUL_HASH0;
        state_d = ST_HASH1;
      end
      ST_HASH1: begin
        cmd_o.mul_op = MUL_HASH1;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register can take the coded bit
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          if (!status_i.last_pass) begin
            state_d = ST_HASH0;
          end else if (!status_i.left_zero) begin
            state_d = ST_SHIFT;
          end else begin
            cmd_o.clear_msg = status_i.last;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign state_o = state_q;

endmodule

@@ src/sce_datapath.sv @@
// ----------------------------------------------------------------------------
// sce_datapath
// Configuration registers, bit shifter, spine and pass hash around one
// shared 32x32 multiplier, and the output register.
// ----------------------------------------------------------------------------
module sce_datapath import sce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic [7:0] data_byte_i,
  input  logic       message_end_i,
  input  cmd_t       cmd_i,
  output status_t    status_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       coded_bit_o,
  output logic [2:0] pass_number_o,
  output logic       run_end_o,
  output logic       message_done_o
);

  logic [3:0]  cfg_k_q, cfg_np_q;
  logic [3:0]  k_eff, np_eff;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [3:0]  left_q, left_new;
  logic [7:0]  pend_bits_q, pend_new;
  logic [3:0]  pend_cnt_q, cnt_new;
  logic [7:0]  sym_q;
  logic        final_q;
  logic [31:0] spine_q, x_q, h_q, h_d;
  logic [2:0]  pass_q;
  logic        more;
  logic [31:0] mul_a, mul_b, prod;
  logic        out_valid_q, coded_q, run_end_q, done_q;
  logic [2:0]  pass_out_q;

  // Clamp the configuration into its meaningful range
  always_comb begin
    k_eff = cfg_k_q;
    if (cfg_k_q == 4'd0) k_eff = 4'd1;
    if (cfg_k_q > MaxSymBits) k_eff = MaxSymBits;
    np_eff = cfg_np_q;
    if (cfg_np_q == 4'd0) np_eff = 4'd1;
    if (cfg_np_q > MaxPasses) np_eff = MaxPasses;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_k_q  <= SymBitsRst;
      cfg_np_q <= PassesRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegSymbolBits) cfg_k_q  <= cfg_wdata_i;
      if (cfg_index_i == RegPasses)     cfg_np_q <= cfg_wdata_i;
    end
  end

  assign left_new = left_q - 4'd1;
  assign pend_new = {pend_bits_q[6:0], byte_q[7]};
  assign cnt_new  = pend_cnt_q + 4'd1;
  assign more     = (left_new >= k_eff) || (last_q && (left_new != 4'd0));

  assign status_o.take      = (cnt_new >= k_eff) || ((left_new == 4'd0) && last_q);
  assign status_o.left_one  = (left_q == 4'd1);
  assign status_o.left_zero = (left_q == 4'd0);
  assign status_o.last_pass = ({1'b0, pass_q} == (np_eff - 4'd1));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;
  assign status_o.last      = last_q;

  // Shared multiplier: operand and constant picked by the current step
  always_comb begin
    mul_a = h_q;
    mul_b = PassMul;
    case (cmd_i.mul_op)
      MUL_MIX0:  begin mul_a = {24'd0, sym_q};         mul_b = MixC1; end
      MUL_MIX1:  begin mul_a = h_q;                    mul_b = MixC2; end
      MUL_MIX2:  begin mul_a = h_q;                    mul_b = MixC3; end
      MUL_MIX3:  begin mul_a = h_q;                    mul_b = MixC4; end
      MUL_HASH0: begin mul_a = x_q ^ (x_q >> 16);      mul_b = PassMul; end
      MUL_HASH1: begin mul_a = h_q ^ (h_q >> 16);      mul_b = PassMul; end
      default:   begin mul_a = h_q;                    mul_b = PassMul; end
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    h_d = h_q;
    case (cmd_i.mul_op)
      MUL_MIX0: h_d = {(spine_q[16:0] ^ prod[16:0]), (spine_q[31:17] ^ prod[31:17])};
      MUL_MIX1: h_d = prod ^ (prod >> 16);
      MUL_MIX2: h_d = prod ^ (prod >> 13);
      MUL_MIX3: h_d = prod ^ (prod >> 16);
      MUL_HASH0, MUL_HASH1: h_d = prod;
      default:  h_d = h_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    if (cmd_i.load_byte) begin
      byte_q <= data_byte_i;
      last_q <= message_end_i;
    end else if (cmd_i.shift_bit) begin
      byte_q <= {byte_q[6:0], 1'b0};
    end
    if (cmd_i.shift_bit && status_o.take) begin
      sym_q   <= pend_new;
      final_q <= !more;
    end
    if (cmd_i.mul_op == MUL_MIX3) begin
      x_q <= h_d;
    end else if (cmd_i.load_out && !status_o.last_pass) begin
      x_q <= x_q + PassInc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= 4'd0;
      pend_bits_q <= 8'd0;
      pend_cnt_q  <= 4'd0;
      spine_q     <= 32'd0;
      pass_q      <= 3'd0;
    end else begin
      if (cmd_i.load_byte) begin
        left_q <= 4'd8;
      end else if (cmd_i.shift_bit) begin
        left_q <= left_new;
        if (status_o.take) begin
          pend_bits_q <= 8'd0;
          pend_cnt_q  <= 4'd0;
        end else begin
          pend_bits_q <= pend_new;
          pend_cnt_q  <= cnt_new;
        end
      end
      if (cmd_i.mul_op == MUL_MIX3) begin
        spine_q <= h_d;
        pass_q  <= 3'd0;
      end else if (cmd_i.clear_msg) begin
        spine_q <= 32'd0;
      end else if (cmd_i.load_out && !status_o.last_pass) begin
        pass_q <= pass_q + 3'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      coded_q    <= h_q[0] ^ h_q[16];
      pass_out_q <= pass_q;
      run_end_q  <= final_q && status_o.last_pass;
      done_q     <= final_q && status_o.last_pass && last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coded_bit_o    = coded_q;
  assign pass_number_o  = pass_out_q;
  assign run_end_o      = run_end_q;
  assign message_done_o = done_q;

endmodule

@@ src/spinal_code_encoder.sv @@
// ----------------------------------------------------------------------------
// spinal_code_encoder
// Spinal code encoder: message bytes in, one coded bit per symbol and pass out.
// ----------------------------------------------------------------------------
// Input channel: one message byte per transaction (in_valid_i/in_ready_o),
// MSB first; message_end_i marks the final byte of a message. Output channel:
// one coded bit per transaction (out_valid_o/out_ready_i) with its pass index,
// run_end_o on the last bit caused by a byte, message_done_o on the last bit
// of the message. Configuration writes (cfg_we_i) take effect at once and
// must be made while the block is idle; the block itself does not enforce it.
// Sequence: a byte is taken in the idle step, then each of its 8 bits is
// shifted in turn; each completed symbol runs the spine mix (MIX0 to MIX3),
// then per pass two multiplier steps (HASH0, HASH1) and one emit, all through
// one shared 32x32 multiplier. The first coded bit of a symbol is loaded into
// the output register at the emit step after HASH0 and HASH1.
// Reset clears the spine, the pending symbol bits, the output valid flag and
// restores symbol_bits = 4, passes = 2. When the receiver stalls, the coded
// bit holds in the output register and the sequencer waits at its emit step.
// ----------------------------------------------------------------------------
module spinal_code_encoder import sce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       message_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       coded_bit_o,
  output logic [2:0] pass_number_o,
  output logic       run_end_o,
  output logic       message_done_o
);

  cmd_t    cmd;
  status_t status;
  state_e  state;

  sce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  sce_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .data_byte_i    (data_byte_i),
    .message_end_i  (message_end_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coded_bit_o    (coded_bit_o),
    .pass_number_o  (pass_number_o),
    .run_end_o      (run_end_o),
    .message_done_o (message_done_o)
  );

  // A coded bit never overwrites one the receiver has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(out_valid_o && !out_ready_i))
    else $error("output register overwritten while stalled");

  // End of message is always the end of a byte's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_done_o |-> run_end_o)
    else $error("message_done without run_end");

  // An accepted byte keeps the input side closed in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && state == ST_SHIFT)
    else $error("input accepted without starting the shift");

endmodule

@@ tb/sce_coded_bit_sb_pkg.sv @@
// ----------------------------------------------------------------------------
// sce_coded_bit_sb_pkg
// Scoreboard for the spinal code encoder: keeps its own spine, pending symbol
// bits and register copies, predicts the coded bits for every accepted byte
// and checks each coded bit the block hands out against the oldest one due.
// ----------------------------------------------------------------------------
package sce_coded_bit_sb_pkg;
  import sce_pkg::*;

  typedef struct packed {
    logic       coded_bit;
    logic [2:0] pass_number;
    logic       run_end;
    logic       message_done;
  } coded_bit_t;

  class coded_bit_scoreboard;
    logic [3:0]  symbol_bits_q;
    logic [3:0]  passes_q;
    logic [31:0] spine;
    logic [7:0]  partial_bits;
    logic [3:0]  partial_count;
    coded_bit_t  coded_bits_due[$];
    int unsigned mismatches;

    function new();
      symbol_bits_q = SymBitsRst;
      passes_q      = PassesRst;
      spine         = '0;
      partial_bits  = '0;
      partial_count = '0;
      mismatches    = 0;
    endfunction

    function void write_register(logic [0:0] index, logic [3:0] value);
      if (index == RegSymbolBits) begin
        symbol_bits_q = value;
      end else begin
        passes_q = value;
      end
    endfunction

    function logic [31:0] spine_mix(logic [31:0] s, logic [7:0] sym);
      logic [31:0] h;
      h = s ^ ({24'b0, sym} * MixC1);
      h = {h[16:0], h[31:17]};
      h = h * MixC2;
      h ^= h >> 16;
      h = h * MixC3;
      h ^= h >> 13;
      h = h * MixC4;
      h ^= h >> 16;
      return h;
    endfunction

    function logic pass_hash(logic [31:0] s, int unsigned pass_idx);
      logic [31:0] x;
      x = s + pass_idx * PassInc;
      x ^= x >> 16;
      x = x * PassMul;
      x ^= x >> 16;
      x = x * PassMul;
      x ^= x >> 16;
      return x[0];
    endfunction

    // Fold one symbol into the spine and queue one coded bit per pass.
    function void code_symbol(logic [7:0] sym, int unsigned num_passes);
      coded_bit_t cb;
      spine = spine_mix(spine, sym);
      for (int unsigned p = 0; p < num_passes; p++) begin
        cb.coded_bit    = pass_hash(spine, p);
        cb.pass_number  = p[2:0];
        cb.run_end      = 1'b0;
        cb.message_done = 1'b0;
        coded_bits_due.push_back(cb);
      end
    endfunction

    function void note_byte(logic [7:0] data, logic last);
      int unsigned k;
      int unsigned num_passes;
      coded_bit_t  tail;
      k          = symbol_bits_q;
      num_passes = passes_q;
      if (k < 1) k = 1;
      if (k > MaxSymBits) k = MaxSymBits;
      if (num_passes < 1) num_passes = 1;
      if (num_passes > MaxPasses) num_passes = MaxPasses;
      for (int b = 7; b >= 0; b--) begin
        partial_bits  = {partial_bits[6:0], data[b]};
        partial_count = partial_count + 4'd1;
        // A shrunken symbol size completes the symbol with all pending bits.
        if (partial_count >= k) begin
          code_symbol(partial_bits, num_passes);
          partial_bits  = '0;
          partial_count = '0;
        end
      end
      if (last) begin
        // Hash a leftover partial symbol right-aligned, no padding.
        if (partial_count > 0) code_symbol(partial_bits, num_passes);
        spine         = '0;
        partial_bits  = '0;
        partial_count = '0;
      end
      tail              = coded_bits_due.pop_back();
      tail.run_end      = 1'b1;
      tail.message_done = last;
      coded_bits_due.push_back(tail);
    endfunction

    function void check_result(longint unsigned stamp, coded_bit_t got);
      coded_bit_t want;
      if (coded_bits_due.size() == 0) begin
        $display("t=%0d ns: coded bit with none due: expected nothing, got %b/%0d/%b/%b",
                 stamp, got.coded_bit, got.pass_number, got.run_end, got.message_done);
        mismatches++;
        return;
      end
      want = coded_bits_due.pop_front();
      if (got.coded_bit !== want.coded_bit) begin
        $display("t=%0d ns: coded_bit expected %b, got %b", stamp, want.coded_bit,
                 got.coded_bit);
        mismatches++;
      end
      if (got.pass_number !== want.pass_number) begin
        $display("t=%0d ns: pass_number expected %0d, got %0d", stamp, want.pass_number,
                 got.pass_number);
        mismatches++;
      end
      if (got.run_end !== want.run_end) begin
        $display("t=%0d ns: run_end expected %b, got %b", stamp, want.run_end, got.run_end);
        mismatches++;
      end
      if (got.message_done !== want.message_done) begin
        $display("t=%0d ns: message_done expected %b, got %b", stamp, want.message_done,
                 got.message_done);
        mismatches++;
      end
    endfunction

    function int unsigned bits_due();
      return coded_bits_due.size();
    endfunction
  endclass

endpackage

@@ tb/tb_spinal_code_encoder.sv @@
// ----------------------------------------------------------------------------
// tb_spinal_code_encoder
// Drives message bytes into the spinal code encoder under random gaps on the
// input and random stalls on the output, across several register settings,
// and checks every coded bit against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_spinal_code_encoder;
  timeunit 1ns;
  timeprecision 1ps;
  import sce_pkg::*;
  import sce_coded_bit_sb_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned RandomBytes = 205;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [0:0] cfg_index_i;
  logic [3:0] cfg_wdata_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] data_byte_i;
  logic       message_end_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       coded_bit_o;
  logic [2:0] pass_number_o;
  logic       run_end_o;
  logic       message_done_o;

  coded_bit_scoreboard sb;
  logic steady;

  spinal_code_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .message_end_i  (message_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .coded_bit_o    (coded_bit_o),
    .pass_number_o  (pass_number_o),
    .run_end_o      (run_end_o),
    .message_done_o (message_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    data_byte_i   <= data;
    message_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(data, last);
  endtask

  // Drop valid, wait until every coded bit due has come out and the block
  // has shifted out the rest of its byte.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.bits_due() != 0) @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [3:0] sym_bits, input logic [3:0] num_passes);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegSymbolBits;
    cfg_wdata_i <= sym_bits;
    @(negedge clk_i);
    cfg_index_i <= RegPasses;
    cfg_wdata_i <= num_passes;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_register(RegSymbolBits, sym_bits);
    sb.write_register(RegPasses, num_passes);
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_ready_i <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result($time, {coded_bit_o, pass_number_o, run_end_o, message_done_o});
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned phase_len;
    logic [3:0]  sym_bits;
    logic [3:0]  num_passes;
    sb            = new();
    steady        = 1'b0;
    random_sent   = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = RegSymbolBits;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    message_end_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, all-zero, all-one and alternating bytes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain();
    // Three-bit symbols leave a partial symbol at message end.
    set_config(4'd3, 4'd8);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b1);
    drain();
    // Most coded bits per byte.
    set_config(4'd1, 4'd8);
    send_byte(8'h96, 1'b1);
    drain();
    // Zero registers act as one.
    set_config(4'd0, 4'd0);
    send_byte(8'h3C, 1'b1);
    drain();
    // Oversized registers act as the maximum.
    set_config(4'd15, 4'd15);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();
    set_config(4'd9, 4'd12);
    send_byte(8'h01, 1'b1);
    drain();
    // Shrink the symbol size while bits are pending.
    set_config(4'd5, 4'd1);
    send_byte(8'hC3, 1'b0);
    drain();
    set_config(4'd2, 4'd3);
    send_byte(8'h7E, 1'b1);
    drain();
    // Grow the symbol size while bits are pending.
    set_config(4'd3, 4'd2);
    send_byte(8'h5B, 1'b0);
    drain();
    set_config(4'd8, 4'd2);
    send_byte(8'hC6, 1'b1);
    drain();
    set_config(4'd8, 4'd1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);

    while (random_sent < RandomBytes) begin
      drain();
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) sym_bits = 4'($urandom_range(0, 15));
      else sym_bits = 4'($urandom_range(1, 8));
      case ($urandom_range(0, 9))
        0: num_passes = 4'($urandom_range(0, 15));
        1: num_passes = MaxPasses;
        default: num_passes = 4'($urandom_range(1, 4));
      endcase
      set_config(sym_bits, num_passes);
      phase_len = $urandom_range(8, 28);
      repeat (phase_len) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
        random_sent++;
      end
    end
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.bits_due() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/sce_pkg.sv
src/sce_ctrl.sv
src/sce_datapath.sv
src/spinal_code_encoder.sv
tb/sce_coded_bit_sb_pkg.sv
tb/tb_spinal_code_encoder.sv
